>>> rtl/assert_macros.svh
// Assertion helpers; expect aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPL(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/csimt_pkg.sv
`timescale 1ns / 1ps
package csimt_pkg;

    localparam int LAT_QMUL    = 2;
    localparam int SQRT_STAGES = 16;
    localparam int DIV_STAGES  = 16;
    localparam int LAT_NORM    = 6 + SQRT_STAGES + 1 + DIV_STAGES + 1;
    localparam int LAT_RMAT    = 5;
    localparam int LAT_TOTAL   = LAT_QMUL + LAT_NORM + LAT_RMAT;

    typedef enum logic [2:0] {
        CFG_ROT_W    = 3'd0,
        CFG_ROT_X    = 3'd1,
        CFG_ROT_Y    = 3'd2,
        CFG_ROT_Z    = 3'd3,
        CFG_SCALE    = 3'd4,
        CFG_OFFSET_X = 3'd5,
        CFG_OFFSET_Y = 3'd6,
        CFG_OFFSET_Z = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] pose_w;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [31:0] pose_z;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } pose_in_t;

    typedef struct packed {
        logic        [30:0] new_w;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
        logic signed [31:0] new_tx;
        logic signed [31:0] new_ty;
        logic signed [31:0] new_tz;
        logic               degenerate;
    } pose_out_t;

    typedef struct packed {
        logic signed [31:0] rot_w;
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic        [30:0] scale;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] qw;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
        logic               deg;
    } unit_q_t;

endpackage

>>> rtl/camera_pose_similarity_transform.sv
// Throughput: one word per cycle; the whole pipeline advances together and
// holds when the result word is not taken. The square root and the four
// divides are 16-stage radix-4 / 2-bit pipelines and set the depth.
// Reset: synchronous, active low; clears valid bits and loads identity config.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module camera_pose_similarity_transform import csimt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  pose_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output pose_out_t  m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t                 cfg_reg;
    logic                 ce;
    logic [LAT_TOTAL-1:0] vld_reg;
    pose_in_t             pass_reg [LAT_TOTAL];
    logic signed [63:0]   r [4];
    unit_q_t              uq;
    pose_out_t            res;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rot_w    <= 32'sh4000_0000;
            cfg_reg.rot_x    <= '0;
            cfg_reg.rot_y    <= '0;
            cfg_reg.rot_z    <= '0;
            cfg_reg.scale    <= 31'h100_0000;
            cfg_reg.offset_x <= '0;
            cfg_reg.offset_y <= '0;
            cfg_reg.offset_z <= '0;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_ROT_W:    cfg_reg.rot_w    <= cfg_data;
                CFG_ROT_X:    cfg_reg.rot_x    <= cfg_data;
                CFG_ROT_Y:    cfg_reg.rot_y    <= cfg_data;
                CFG_ROT_Z:    cfg_reg.rot_z    <= cfg_data;
                CFG_SCALE:    cfg_reg.scale    <= cfg_data[30:0];
                CFG_OFFSET_X: cfg_reg.offset_x <= cfg_data;
                CFG_OFFSET_Y: cfg_reg.offset_y <= cfg_data;
                CFG_OFFSET_Z: cfg_reg.offset_z <= cfg_data;
                default: ;
            endcase
        end
    end

    assign ce      = !m_valid || m_ready;
    assign s_ready = ce && aresetn;
    assign m_valid = vld_reg[LAT_TOTAL-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[LAT_TOTAL-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pass_reg[0] <= s_data;
            for (int k = 1; k < LAT_TOTAL; k++) begin
                pass_reg[k] <= pass_reg[k-1];
            end
        end
    end

    csimt_qmul u_qmul (
        .aclk    (aclk),
        .ce      (ce),
        .in_word (s_data),
        .cfg     (cfg_reg),
        .r_o     (r)
    );

    csimt_norm u_norm (
        .aclk (aclk),
        .ce   (ce),
        .r_i  (r),
        .q_o  (uq)
    );

    csimt_rmat u_rmat (
        .aclk   (aclk),
        .ce     (ce),
        .q_i    (uq),
        .cfg    (cfg_reg),
        .pass_i (pass_reg[LAT_QMUL+LAT_NORM-1]),
        .res_o  (res)
    );

    always_comb begin
        if (res.degenerate) begin
            m_data.new_w      = pass_reg[LAT_TOTAL-1].pose_w[30:0];
            m_data.new_x      = pass_reg[LAT_TOTAL-1].pose_x;
            m_data.new_y      = pass_reg[LAT_TOTAL-1].pose_y;
            m_data.new_z      = pass_reg[LAT_TOTAL-1].pose_z;
            m_data.new_tx     = pass_reg[LAT_TOTAL-1].trans_x;
            m_data.new_ty     = pass_reg[LAT_TOTAL-1].trans_y;
            m_data.new_tz     = pass_reg[LAT_TOTAL-1].trans_z;
            m_data.degenerate = 1'b1;
        end else begin
            m_data = res;
        end
    end

    `CHK_IMPL(a_w_unit, (m_valid && !m_data.degenerate) |-> (m_data.new_w <= 31'h4000_0000), "normalized w above one")
    `CHK_IMPL(a_x_unit, (m_valid && !m_data.degenerate) |-> (m_data.new_x <= 32'sh4000_0000 && m_data.new_x >= -32'sh4000_0000), "normalized x out of range")
    `CHK_NEXT(a_stall_hold, !s_ready, $stable(vld_reg), "pipeline moved while stalled")

endmodule

>>> rtl/csimt_qmul.sv
`timescale 1ns / 1ps
module csimt_qmul import csimt_pkg::*; (
    input  logic               aclk,
    input  logic               ce,
    input  pose_in_t           in_word,
    input  cfg_t               cfg,
    output logic signed [63:0] r_o [4]
);

    logic signed [31:0] a [4];
    logic signed [32:0] b [4];
    logic signed [64:0] prod_reg [4][4];
    logic signed [63:0] r_reg [4];
    logic signed [66:0] s [4];

    assign a[0] = in_word.pose_w;
    assign a[1] = in_word.pose_x;
    assign a[2] = in_word.pose_y;
    assign a[3] = in_word.pose_z;
    assign b[0] = {cfg.rot_w[31], cfg.rot_w};
    assign b[1] = -{cfg.rot_x[31], cfg.rot_x};
    assign b[2] = -{cfg.rot_y[31], cfg.rot_y};
    assign b[3] = -{cfg.rot_z[31], cfg.rot_z};

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    prod_reg[i][j] <= a[i] * b[j];
                end
            end
        end
    end

    // Hamilton product, a * b
    always_comb begin
        s[0] = 67'(prod_reg[0][0]) - 67'(prod_reg[1][1])
             - 67'(prod_reg[2][2]) - 67'(prod_reg[3][3]);
        s[1] = 67'(prod_reg[0][1]) + 67'(prod_reg[1][0])
             + 67'(prod_reg[2][3]) - 67'(prod_reg[3][2]);
        s[2] = 67'(prod_reg[0][2]) - 67'(prod_reg[1][3])
             + 67'(prod_reg[2][0]) + 67'(prod_reg[3][1]);
        s[3] = 67'(prod_reg[0][3]) + 67'(prod_reg[1][2])
             - 67'(prod_reg[2][1]) + 67'(prod_reg[3][0]);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 4; i++) begin
                r_reg[i] <= s[i][65:2];
            end
        end
    end

    assign r_o = r_reg;

endmodule

>>> rtl/csimt_norm.sv
`timescale 1ns / 1ps
module csimt_norm import csimt_pkg::*; (
    input  logic               aclk,
    input  logic               ce,
    input  logic signed [63:0] r_i [4],
    output unit_q_t            q_o
);

    typedef struct packed {
        logic [3:0][29:0] mag;
        logic [3:0]       neg;
        logic             deg;
    } side_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } sq_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] low;
        logic [31:0] quo;
    } dv_t;

    function automatic sq_t sqrt2(sq_t s);
        sq_t         o;
        logic [35:0] rem_w;
        logic [35:0] trial;
        o = s;
        for (int i = 0; i < 2; i++) begin
            rem_w = {o.rem, o.rad[63:62]};
            trial = {2'b00, o.root, 2'b01};
            if (rem_w >= trial) begin
                rem_w  = rem_w - trial;
                o.root = {o.root[30:0], 1'b1};
            end else begin
                o.root = {o.root[30:0], 1'b0};
            end
            o.rem = rem_w[33:0];
            o.rad = {o.rad[61:0], 2'b00};
        end
        return o;
    endfunction

    function automatic dv_t div2(dv_t d, logic [30:0] den);
        dv_t         o;
        logic [32:0] t;
        o = d;
        for (int i = 0; i < 2; i++) begin
            t = {o.rem, o.low[31]};
            if (t >= {2'b00, den}) begin
                t     = t - {2'b00, den};
                o.quo = {o.quo[30:0], 1'b1};
            end else begin
                o.quo = {o.quo[30:0], 1'b0};
            end
            o.rem = t[31:0];
            o.low = {o.low[30:0], 1'b0};
        end
        return o;
    endfunction

    // magnitude
    logic [62:0] mag1_reg [4];
    logic [3:0]  neg1_reg;
    // max
    logic [62:0] mag2_reg [4];
    logic [3:0]  neg2_reg;
    logic [62:0] m2_reg;
    logic [62:0] m01, m23;
    // shift amount
    logic [62:0] mag3_reg [4];
    logic [3:0]  neg3_reg;
    logic [5:0]  rs3_reg, ls3_reg;
    logic        deg3_reg;
    logic [5:0]  pos;
    // normalized
    side_t       sd4_reg, sd5_reg, sd6_reg;
    logic [62:0] shf [4];
    logic [59:0] sq5_reg [4];
    logic [61:0] sum6_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 4; i++) begin
                mag1_reg[i] <= r_i[i][63] ? 63'(-r_i[i]) : r_i[i][62:0];
                neg1_reg[i] <= r_i[i][63];
            end
        end
    end

    always_comb begin
        m01 = (mag1_reg[0] > mag1_reg[1]) ? mag1_reg[0] : mag1_reg[1];
        m23 = (mag1_reg[2] > mag1_reg[3]) ? mag1_reg[2] : mag1_reg[3];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
            m2_reg   <= (m01 > m23) ? m01 : m23;
        end
    end

    always_comb begin
        pos = 6'd0;
        for (int k = 0; k < 63; k++) begin
            if (m2_reg[k]) begin
                pos = 6'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
            rs3_reg  <= (pos > 6'd29) ? pos - 6'd29 : 6'd0;
            ls3_reg  <= (pos < 6'd29) ? 6'd29 - pos : 6'd0;
            deg3_reg <= (m2_reg == '0);
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            shf[i] = (mag3_reg[i] >> rs3_reg) << ls3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 4; i++) begin
                sd4_reg.mag[i] <= shf[i][29:0];
            end
            sd4_reg.neg <= neg3_reg;
            sd4_reg.deg <= deg3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 4; i++) begin
                sq5_reg[i] <= sd4_reg.mag[i] * sd4_reg.mag[i];
            end
            sd5_reg <= sd4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sum6_reg <= 62'(sq5_reg[0]) + 62'(sq5_reg[1])
                      + 62'(sq5_reg[2]) + 62'(sq5_reg[3]);
            sd6_reg  <= sd5_reg;
        end
    end

    // integer square root, two result bits per stage
    sq_t   sq_reg [SQRT_STAGES];
    side_t sq_sd_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
        if (k == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (ce) begin
                    sq_reg[k]    <= sqrt2('{rem: '0, root: '0, rad: {2'b00, sum6_reg}});
                    sq_sd_reg[k] <= sd6_reg;
                end
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (ce) begin
                    sq_reg[k]    <= sqrt2(sq_reg[k-1]);
                    sq_sd_reg[k] <= sq_sd_reg[k-1];
                end
            end
        end
    end

    // dividend set-up: mag * 2^30 + n / 2
    logic [30:0] n;
    logic [60:0] num [4];
    dv_t         pv_reg [4];
    logic [30:0] pv_den_reg;
    side_t       pv_sd_reg;

    assign n = sq_reg[SQRT_STAGES-1].root[30:0];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            num[i] = {1'b0, sq_sd_reg[SQRT_STAGES-1].mag[i], 30'd0} + 61'(n >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 4; i++) begin
                pv_reg[i] <= '{rem: 32'(num[i][60:32]), low: num[i][31:0], quo: '0};
            end
            pv_den_reg <= n;
            pv_sd_reg  <= sq_sd_reg[SQRT_STAGES-1];
        end
    end

    // long division, two quotient bits per stage
    dv_t         dv_reg [DIV_STAGES][4];
    logic [30:0] dv_den_reg [DIV_STAGES];
    side_t       dv_sd_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        if (k == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (ce) begin
                    for (int i = 0; i < 4; i++) begin
                        dv_reg[k][i] <= div2(pv_reg[i], pv_den_reg);
                    end
                    dv_den_reg[k] <= pv_den_reg;
                    dv_sd_reg[k]  <= pv_sd_reg;
                end
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (ce) begin
                    for (int i = 0; i < 4; i++) begin
                        dv_reg[k][i] <= div2(dv_reg[k-1][i], dv_den_reg[k-1]);
                    end
                    dv_den_reg[k] <= dv_den_reg[k-1];
                    dv_sd_reg[k]  <= dv_sd_reg[k-1];
                end
            end
        end
    end

    // sign: follow r_i, all flipped when r_w is negative
    logic signed [31:0] qv [4];
    logic               flip;
    unit_q_t            q_reg;

    assign flip = dv_sd_reg[DIV_STAGES-1].neg[0];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qv[i] = (dv_sd_reg[DIV_STAGES-1].neg[i] ^ flip)
                  ? -$signed(dv_reg[DIV_STAGES-1][i].quo)
                  : $signed(dv_reg[DIV_STAGES-1][i].quo);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            q_reg.qw  <= qv[0];
            q_reg.qx  <= qv[1];
            q_reg.qy  <= qv[2];
            q_reg.qz  <= qv[3];
            q_reg.deg <= dv_sd_reg[DIV_STAGES-1].deg;
        end
    end

    assign q_o = q_reg;

endmodule

>>> rtl/csimt_rmat.sv
`timescale 1ns / 1ps
module csimt_rmat import csimt_pkg::*; (
    input  logic      aclk,
    input  logic      ce,
    input  unit_q_t   q_i,
    input  cfg_t      cfg,
    input  pose_in_t  pass_i,
    output pose_out_t res_o
);

    localparam logic signed [65:0] ONE_Q60  = 66'sd1 <<< 60;
    localparam logic signed [65:0] HALF_Q30 = 66'sd1 <<< 29;
    localparam logic signed [66:0] HALF_Q24 = 67'sd1 <<< 23;

    unit_q_t            q1_reg, q2_reg, q3_reg, q4_reg;
    logic signed [63:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [63:0] xw_reg, yw_reg, zw_reg;
    logic signed [63:0] st1_reg [3], st2_reg [3], st3_reg [3];
    logic signed [31:0] t [3];
    logic signed [31:0] off [3];
    logic signed [31:0] sc;

    assign t[0]   = pass_i.trans_x;
    assign t[1]   = pass_i.trans_y;
    assign t[2]   = pass_i.trans_z;
    assign off[0] = cfg.offset_x;
    assign off[1] = cfg.offset_y;
    assign off[2] = cfg.offset_z;
    assign sc     = $signed({1'b0, cfg.scale});

    always_ff @(posedge aclk) begin
        if (ce) begin
            xx_reg <= q_i.qx * q_i.qx;
            yy_reg <= q_i.qy * q_i.qy;
            zz_reg <= q_i.qz * q_i.qz;
            xy_reg <= q_i.qx * q_i.qy;
            xz_reg <= q_i.qx * q_i.qz;
            yz_reg <= q_i.qy * q_i.qz;
            xw_reg <= q_i.qx * q_i.qw;
            yw_reg <= q_i.qy * q_i.qw;
            zw_reg <= q_i.qz * q_i.qw;
            for (int i = 0; i < 3; i++) begin
                st1_reg[i] <= sc * t[i];
            end
            q1_reg <= q_i;
        end
    end

    logic signed [65:0] rq [9];
    logic signed [65:0] rr [9];
    logic signed [33:0] rm_reg [9];

    always_comb begin
        rq[0] = ONE_Q60 - 66'(yy_reg + zz_reg) * 2;
        rq[1] = 66'(xy_reg - zw_reg) * 2;
        rq[2] = 66'(xz_reg + yw_reg) * 2;
        rq[3] = 66'(xy_reg + zw_reg) * 2;
        rq[4] = ONE_Q60 - 66'(xx_reg + zz_reg) * 2;
        rq[5] = 66'(yz_reg - xw_reg) * 2;
        rq[6] = 66'(xz_reg - yw_reg) * 2;
        rq[7] = 66'(yz_reg + xw_reg) * 2;
        rq[8] = ONE_Q60 - 66'(xx_reg + yy_reg) * 2;
        for (int i = 0; i < 9; i++) begin
            rr[i] = (rq[i] + HALF_Q30) >>> 30;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 9; i++) begin
                rm_reg[i] <= rr[i][33:0];
            end
            st2_reg <= st1_reg;
            q2_reg  <= q1_reg;
        end
    end

    logic signed [65:0] rp_reg [9];

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    rp_reg[i*3+j] <= rm_reg[i*3+j] * off[j];
                end
            end
            st3_reg <= st2_reg;
            q3_reg  <= q2_reg;
        end
    end

    logic signed [67:0] rot [3];
    logic signed [65:0] v [3];
    logic signed [65:0] v4_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rot[i] = 68'(rp_reg[i*3]) + 68'(rp_reg[i*3+1]) + 68'(rp_reg[i*3+2]);
            v[i]   = 66'(st3_reg[i]) - 66'(rot[i] >>> 6);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            v4_reg <= v;
            q4_reg <= q3_reg;
        end
    end

    logic signed [66:0] w [3];
    logic signed [31:0] ts [3];
    pose_out_t          res_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w[i] = (67'(v4_reg[i]) + HALF_Q24) >>> 24;
            if (w[i] > 67'sh7FFF_FFFF) begin
                ts[i] = 32'sh7FFF_FFFF;
            end else if (w[i] < -67'sh8000_0000) begin
                ts[i] = 32'sh8000_0000;
            end else begin
                ts[i] = w[i][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            res_reg.new_w      <= q4_reg.qw[30:0];
            res_reg.new_x      <= q4_reg.qx;
            res_reg.new_y      <= q4_reg.qy;
            res_reg.new_z      <= q4_reg.qz;
            res_reg.new_tx     <= ts[0];
            res_reg.new_ty     <= ts[1];
            res_reg.new_tz     <= ts[2];
            res_reg.degenerate <= q4_reg.deg;
        end
    end

    assign res_o = res_reg;

endmodule

>>> tb/sv/tb_camera_pose_similarity_transform.sv
`timescale 1ns / 1ps
module tb_camera_pose_similarity_transform;
    import csimt_pkg::*;

    localparam int LATENCY = 47;
    localparam longint LIMIT = 2000000;

    class pose_scoreboard;
        pose_out_t pending[$];
        int mismatches;
        int unmatched;
        logic signed [31:0] rw, rx, ry, rz;
        logic [30:0] scl;
        logic signed [31:0] ux, uy, uz;

        function void set_identity();
            rw = 32'sd1 << 30; rx = 0; ry = 0; rz = 0;
            scl = 31'd1 << 24; ux = 0; uy = 0; uz = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] val);
            case (idx)
                CFG_ROT_W:    rw = val;
                CFG_ROT_X:    rx = val;
                CFG_ROT_Y:    ry = val;
                CFG_ROT_Z:    rz = val;
                CFG_SCALE:    scl = val[30:0];
                CFG_OFFSET_X: ux = val;
                CFG_OFFSET_Y: uy = val;
                CFG_OFFSET_Z: uz = val;
                default: ;
            endcase
        endfunction

        function longint quarter(longint p0, longint p1, longint p2, longint p3);
            longint hi;
            longint lo;
            hi = (p0 >>> 2) + (p1 >>> 2) + (p2 >>> 2) + (p3 >>> 2);
            lo = (p0 & 3) + (p1 & 3) + (p2 & 3) + (p3 & 3);
            return hi + (lo >>> 2);
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function pose_out_t move_pose(pose_in_t p);
            pose_out_t o;
            longint aw, ax, ay, az, bw, bx, by, bz;
            longint r[4], q[4], rm[9], off[3], tr[3];
            longint unsigned mag[4], m, sum, n;
            int rs, ls;
            bit flip;
            longint acc, v;
            aw = p.pose_w; ax = p.pose_x; ay = p.pose_y; az = p.pose_z;
            bw = rw; bx = -longint'(rx); by = -longint'(ry); bz = -longint'(rz);
            r[0] = quarter(aw * bw, -(ax * bx), -(ay * by), -(az * bz));
            r[1] = quarter(aw * bx, ax * bw, ay * bz, -(az * by));
            r[2] = quarter(aw * by, -(ax * bz), ay * bw, az * bx);
            r[3] = quarter(aw * bz, ax * by, -(ay * bx), az * bw);
            m = 0;
            for (int i = 0; i < 4; i++) begin
                mag[i] = r[i] < 0 ? -r[i] : r[i];
                if (mag[i] > m) m = mag[i];
            end
            if (m == 0) begin
                o.new_w = p.pose_w[30:0];
                o.new_x = p.pose_x; o.new_y = p.pose_y; o.new_z = p.pose_z;
                o.new_tx = p.trans_x; o.new_ty = p.trans_y; o.new_tz = p.trans_z;
                o.degenerate = 1'b1;
                return o;
            end
            rs = 0; ls = 0; sum = 0;
            while (m >= (64'd1 << 30)) begin m >>= 1; rs++; end
            while (m < (64'd1 << 29)) begin m <<= 1; ls++; end
            for (int i = 0; i < 4; i++) begin
                mag[i] = (mag[i] >> rs) << ls;
                sum += mag[i] * mag[i];
            end
            n = int_sqrt(sum);
            flip = r[0] < 0;
            for (int i = 0; i < 4; i++) begin
                v = ((mag[i] << 30) + (n >> 1)) / n;
                q[i] = ((r[i] < 0) != flip) ? -v : v;
            end
            rm[0] = (64'sd1 << 60) - 2 * (q[2] * q[2] + q[3] * q[3]);
            rm[1] = 2 * (q[1] * q[2] - q[3] * q[0]);
            rm[2] = 2 * (q[1] * q[3] + q[2] * q[0]);
            rm[3] = 2 * (q[1] * q[2] + q[3] * q[0]);
            rm[4] = (64'sd1 << 60) - 2 * (q[1] * q[1] + q[3] * q[3]);
            rm[5] = 2 * (q[2] * q[3] - q[1] * q[0]);
            rm[6] = 2 * (q[1] * q[3] - q[2] * q[0]);
            rm[7] = 2 * (q[2] * q[3] + q[1] * q[0]);
            rm[8] = (64'sd1 << 60) - 2 * (q[1] * q[1] + q[2] * q[2]);
            for (int i = 0; i < 9; i++) rm[i] = (rm[i] + (64'sd1 << 29)) >>> 30;
            off[0] = ux; off[1] = uy; off[2] = uz;
            tr[0] = p.trans_x; tr[1] = p.trans_y; tr[2] = p.trans_z;
            o.new_w = q[0][30:0];
            o.new_x = q[1][31:0]; o.new_y = q[2][31:0]; o.new_z = q[3][31:0];
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int j = 0; j < 3; j++) acc += rm[i * 3 + j] * off[j];
                v = longint'({1'b0, scl}) * tr[i] - (acc >>> 6);
                v = (v + (64'sd1 << 23)) >>> 24;
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                if (v < -64'sd2147483648) v = -64'sd2147483648;
                if (i == 0) o.new_tx = v[31:0];
                else if (i == 1) o.new_ty = v[31:0];
                else o.new_tz = v[31:0];
            end
            o.degenerate = 1'b0;
            return o;
        endfunction

        function void note_pose(pose_in_t p);
            pending.insert(pending.size(), move_pose(p));
        endfunction

        function void check_result(pose_out_t got);
            pose_out_t exp_word;
            if (pending.size() == 0) begin
                unmatched++;
                $display("unexpected result word %h", got);
                return;
            end
            exp_word = pending.pop_front();
            if (got !== exp_word) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp w=%h x=%h y=%h z=%h t=%h %h %h d=%b",
                        exp_word.new_w, exp_word.new_x, exp_word.new_y, exp_word.new_z,
                        exp_word.new_tx, exp_word.new_ty, exp_word.new_tz,
                        exp_word.degenerate);
                    $display("          got w=%h x=%h y=%h z=%h t=%h %h %h d=%b",
                        got.new_w, got.new_x, got.new_y, got.new_z,
                        got.new_tx, got.new_ty, got.new_tz, got.degenerate);
                end
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    pose_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pose_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    pose_scoreboard board;
    longint cycles = 0;
    int sink_idle_pct = 27;
    int src_idle_pct = 27;
    bit hold_sink = 1'b0;

    always #6 aclk = ~aclk;

    camera_pose_similarity_transform dut (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_camera_pose_similarity_transform NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
        m_ready <= !hold_sink && ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic write_cfg(cfg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_pose(pose_in_t p);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= p;
        do @(posedge aclk); while (!s_ready);
        board.note_pose(p);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    function automatic logic [31:0] unit_comp();
        case ($urandom_range(5))
            0: return 32'sd1 << 30;
            1: return -(32'sd1 << 30);
            2: return 0;
            default: return $urandom_range(32'h7FFF_FFFF, 0) - 32'sh4000_0000;
        endcase
    endfunction

    function automatic pose_in_t rand_pose();
        pose_in_t p;
        if ($urandom_range(3) == 0) begin
            p.pose_w = $urandom; p.pose_x = $urandom;
            p.pose_y = $urandom; p.pose_z = $urandom;
        end else begin
            p.pose_w = unit_comp(); p.pose_x = unit_comp();
            p.pose_y = unit_comp(); p.pose_z = unit_comp();
        end
        if ($urandom_range(1)) begin
            p.trans_x = $urandom; p.trans_y = $urandom; p.trans_z = $urandom;
        end else begin
            p.trans_x = $urandom_range(2000000) - 1000000;
            p.trans_y = $urandom_range(2000000) - 1000000;
            p.trans_z = $urandom_range(2000000) - 1000000;
        end
        return p;
    endfunction

    task automatic random_config();
        for (int i = 0; i < 4; i++)
            write_cfg(cfg_idx_t'(i), ($urandom_range(7) == 0) ? $urandom : unit_comp());
        write_cfg(CFG_SCALE, ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0400_0000));
        for (int i = 5; i < 8; i++)
            write_cfg(cfg_idx_t'(i), ($urandom_range(1)) ? $urandom
                                     : $urandom_range(2000000) - 1000000);
    endtask

    initial begin
        pose_in_t p;
        logic [31:0] ext[4];
        board = new();
        board.set_identity();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: identity config, extremes, degenerate
        ext[0] = 32'h8000_0000; ext[1] = 32'h7FFF_FFFF; ext[2] = 0; ext[3] = 32'h4000_0000;
        for (int i = 0; i < 4; i++) begin
            p = '{ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[(i + 3) % 4],
                  ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]};
            send_pose(p);
        end
        send_pose('0);
        send_pose('{32'hC000_0000, 0, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF});
        send_pose('{1, 0, 0, 0, 5, 6, 7});
        send_pose('{32'h0000_0001, 32'h0000_0001, 0, 0, 0, 0, 0});
        drain();

        // extreme config: max scale, offsets at min/max/min, negative rotation
        write_cfg(CFG_ROT_W, 32'hC000_0000);
        write_cfg(CFG_ROT_X, 32'h4000_0000);
        write_cfg(CFG_ROT_Y, 32'hC000_0000);
        write_cfg(CFG_ROT_Z, 32'h4000_0000);
        write_cfg(CFG_SCALE, 32'h7FFF_FFFF);
        write_cfg(CFG_OFFSET_X, 32'h8000_0000);
        write_cfg(CFG_OFFSET_Y, 32'h7FFF_FFFF);
        write_cfg(CFG_OFFSET_Z, 32'h8000_0000);
        for (int i = 0; i < 4; i++) begin
            p = '{ext[i], ext[(i + 3) % 4], ext[(i + 2) % 4], ext[(i + 1) % 4],
                  ext[(i + 1) % 4], ext[i], ext[(i + 3) % 4]};
            send_pose(p);
        end
        send_pose('{32'h4000_0000, 0, 0, 0, 0, 0, 0});
        drain();

        // all-zero rotation and zero scale
        for (int i = 0; i < 5; i++) write_cfg(cfg_idx_t'(i), 0);
        send_pose(rand_pose());
        send_pose(rand_pose());
        drain();

        // random phases
        for (int ph = 0; ph < 10; ph++) begin
            random_config();
            if (ph == 2) begin
                sink_idle_pct = 0;
                src_idle_pct = 0;
            end else begin
                sink_idle_pct = 27;
                src_idle_pct = 27;
            end
            if (ph == 4) begin
                fork
                    begin
                        hold_sink = 1'b1;
                        repeat (200) @(posedge aclk);
                        hold_sink = 1'b0;
                    end
                    for (int k = 0; k < 100; k++) send_pose(rand_pose());
                join
            end else begin
                for (int k = 0; k < 100; k++) send_pose(rand_pose());
            end
            drain();
        end

        if (board.mismatches == 0 && board.unmatched == 0 && board.pending.size() == 0)
            $display("tb_camera_pose_similarity_transform OK");
        else
            $display("tb_camera_pose_similarity_transform NOT OK");
        $finish;
    end
endmodule
